// ===== hw/rtl/pqbsf_pkg.sv =====
// pqbsf_pkg: shared codes, types and helpers of the position query framer
// no dependencies; used by every module of the framer

package pqbsf_pkg;

   localparam logic [7:0] FRAME_START = 8'hAA;
   localparam logic [7:0] FRAME_END   = 8'hBB;
   localparam logic [7:0] ESC_MARK    = 8'h7D;
   localparam logic [7:0] ESC_FLIP    = 8'h20;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_HELP  = 2'd2;

   localparam int unsigned BODY_BYTES = 6;

   // one classified command waiting for the serializer
   typedef struct packed {
      logic [1:0]                      kind;
      logic [BODY_BYTES-1:0][7:0]      body;
      logic [BODY_BYTES-1:0]           esc;
   } frame_desc_type;

   typedef enum logic [3:0] {
      PH_HEAD = 4'b0001,
      PH_BODY = 4'b0010,
      PH_ESC  = 4'b0100,
      PH_TAIL = 4'b1000
   } back_state_type;

   function automatic logic needs_escape(input logic [7:0] value);
      needs_escape = (value == FRAME_START) || (value == FRAME_END) || (value == ESC_MARK);
   endfunction

endpackage

// ===== hw/rtl/pqbsf_if.sv =====
// pqbsf_req_if / pqbsf_rsp_if: valid/ready channels of the position query framer
// no dependencies

interface pqbsf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command_byte;
   logic [15:0] position_first;
   logic [15:0] position_second;
   logic [15:0] position_third;

   modport source (output valid, output command_byte, output position_first,
                   output position_second, output position_third, input ready);
   modport sink   (input valid, input command_byte, input position_first,
                   input position_second, input position_third, output ready);
endinterface

interface pqbsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] line_byte;
   logic       last_of_run;

   modport source (output valid, output result_kind, output line_byte,
                   output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input line_byte,
                   input last_of_run, output ready);
endinterface

// ===== hw/rtl/pqbsf_front.sv =====
// pqbsf_front: takes command beats and classifies them into frame descriptors
// depends on pqbsf_pkg and pqbsf_req_if

module pqbsf_front (
   pqbsf_req_if.sink                 req_chan,
   output logic                      push_valid,
   input  logic                      push_ready,
   output pqbsf_pkg::frame_desc_type push_desc
);

   logic [pqbsf_pkg::BODY_BYTES-1:0][7:0] body;

   assign body[0] = req_chan.position_first[15:8];
   assign body[1] = req_chan.position_first[7:0];
   assign body[2] = req_chan.position_second[15:8];
   assign body[3] = req_chan.position_second[7:0];
   assign body[4] = req_chan.position_third[15:8];
   assign body[5] = req_chan.position_third[7:0];

   always_comb begin
      if (req_chan.command_byte == pqbsf_pkg::FRAME_START) begin
         push_desc.kind = pqbsf_pkg::KIND_BYTE;
      end else if (req_chan.command_byte == pqbsf_pkg::FRAME_END) begin
         push_desc.kind = pqbsf_pkg::KIND_RESET;
      end else begin
         push_desc.kind = pqbsf_pkg::KIND_HELP;
      end
      push_desc.body = body;
      for (int i = 0; i < pqbsf_pkg::BODY_BYTES; i++) begin
         push_desc.esc[i] = pqbsf_pkg::needs_escape(body[i]);
      end
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

// ===== hw/rtl/pqbsf_queue.sv =====
// pqbsf_queue: small descriptor fifo between classifier and serializer
// depends on pqbsf_pkg

module pqbsf_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  pqbsf_pkg::frame_desc_type push_desc,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output pqbsf_pkg::frame_desc_type pop_desc
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pqbsf_pkg::frame_desc_type slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== hw/rtl/pqbsf_back.sv =====
// pqbsf_back: serializes one descriptor into result beats with byte stuffing
// depends on pqbsf_pkg and pqbsf_rsp_if

module pqbsf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   output logic                      head_pop,
   input  pqbsf_pkg::frame_desc_type head_desc,
   pqbsf_rsp_if.source               rsp_chan
);

   pqbsf_pkg::back_state_type state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       load;
   logic [7:0] cur_byte;

   // output register frees up when empty or being taken this cycle
   assign load     = head_valid && (!out_valid_ff || rsp_chan.ready);
   assign cur_byte = head_desc.body[idx_ff];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      head_pop     = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         out_kind_in  = head_desc.kind;
         out_last_in  = 1'b0;
         if (head_desc.kind != pqbsf_pkg::KIND_BYTE) begin
            out_byte_in = '0;
            out_last_in = 1'b1;
            head_pop    = 1'b1;
         end else begin
            unique case (state_ff)
               pqbsf_pkg::PH_HEAD: begin
                  out_byte_in = pqbsf_pkg::FRAME_START;
                  idx_in      = '0;
                  state_in    = pqbsf_pkg::PH_BODY;
               end
               pqbsf_pkg::PH_BODY: begin
                  if (head_desc.esc[idx_ff]) begin
                     out_byte_in = pqbsf_pkg::ESC_MARK;
                     state_in    = pqbsf_pkg::PH_ESC;
                  end else begin
                     out_byte_in = cur_byte;
                     if (idx_ff == 3'(pqbsf_pkg::BODY_BYTES - 1)) begin
                        state_in = pqbsf_pkg::PH_TAIL;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
               end
               pqbsf_pkg::PH_ESC: begin
                  out_byte_in = cur_byte ^ pqbsf_pkg::ESC_FLIP;
                  if (idx_ff == 3'(pqbsf_pkg::BODY_BYTES - 1)) begin
                     state_in = pqbsf_pkg::PH_TAIL;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = pqbsf_pkg::PH_BODY;
                  end
               end
               pqbsf_pkg::PH_TAIL: begin
                  out_byte_in = pqbsf_pkg::FRAME_END;
                  out_last_in = 1'b1;
                  head_pop    = 1'b1;
                  state_in    = pqbsf_pkg::PH_HEAD;
               end
               default: begin
                  state_in = pqbsf_pkg::PH_HEAD;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pqbsf_pkg::PH_HEAD;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_kind = out_kind_ff;
   assign rsp_chan.line_byte   = out_byte_ff;
   assign rsp_chan.last_of_run = out_last_ff;

endmodule

// ===== hw/rtl/position_query_byte_stuffed_framer.sv =====
// Position query framer: a command 0xAA with three 16-bit positions becomes a frame of
// 8 to 14 byte beats (0xAA, six position bytes high first with 0x7D/xor-0x20 stuffing of
// 0xAA, 0xBB and 0x7D, then 0xBB); 0xBB gives one counter reset beat, any other command
// one help beat. The back end puts out one beat per cycle while the result side is ready;
// a query takes the serializer for one beat per frame byte, any other command for a single beat.
// The front classifies commands into a QUEUE_DEPTH-entry queue, so new commands are
// taken while a frame is still going out; the result side has its own output register.
// depends on pqbsf_pkg, pqbsf_if, pqbsf_front, pqbsf_queue, pqbsf_back

module position_query_byte_stuffed_framer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   pqbsf_req_if.sink   req_chan,
   pqbsf_rsp_if.source rsp_chan
);

   logic                      push_valid, push_ready;
   logic                      pop_valid, pop_ready;
   pqbsf_pkg::frame_desc_type push_desc, pop_desc;

   pqbsf_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc)
   );

   pqbsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   pqbsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (pop_valid),
      .head_pop   (pop_ready),
      .head_desc  (pop_desc),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTHESIS
   // single-beat results carry no byte and close their run
   a_ctrl_beat_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.result_kind != pqbsf_pkg::KIND_BYTE)
      |-> (rsp_chan.last_of_run && rsp_chan.line_byte == 8'h00))
      else $error("control result with byte or without last");

   // a frame always closes on the end byte
   a_frame_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.result_kind == pqbsf_pkg::KIND_BYTE
       && rsp_chan.last_of_run) |-> (rsp_chan.line_byte == pqbsf_pkg::FRAME_END))
      else $error("frame closed on a byte other than the end byte");

   // serializer retires only descriptors that are really queued
   a_pop_guard: assert property (@(posedge clock) disable iff (reset)
      pop_ready |-> pop_valid)
      else $error("queue popped while empty");
`endif

endmodule

// ===== tb/sv/tb_position_query_byte_stuffed_framer.sv =====
`timescale 1ns / 100ps
// tb_position_query_byte_stuffed_framer: self-checking bench for the position query framer
// predicts the frame, reset and help beats of every accepted command and checks them in order
// depends on pqbsf_pkg, pqbsf_if and position_query_byte_stuffed_framer

module tb_position_query_byte_stuffed_framer;

   localparam int unsigned STALL_PERCENT = 36;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 50;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } line_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic stall_enable = 1'b1;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   line_beat_type expected_beats[$];

   pqbsf_req_if req_bus ();
   pqbsf_rsp_if rsp_bus ();

   position_query_byte_stuffed_framer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.command_byte = 8'h00;
      req_bus.position_first = 16'h0000;
      req_bus.position_second = 16'h0000;
      req_bus.position_third = 16'h0000;
      rsp_bus.ready = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      fail_count++;
      $display("%0t: mismatch in %s: expected 0x%02h, got 0x%02h", $realtime, what, want, got);
   endtask

   // ---------------- prediction ----------------

   function automatic void push_beat(input logic [1:0] kind, input logic [7:0] data);
      line_beat_type beat;
      beat.kind = kind;
      beat.data = data;
      beat.last = 1'b0;
      expected_beats.push_back(beat);
   endfunction

   function automatic void push_stuffed_byte(input logic [7:0] value);
      if (value == pqbsf_pkg::FRAME_START || value == pqbsf_pkg::FRAME_END
          || value == pqbsf_pkg::ESC_MARK) begin
         push_beat(pqbsf_pkg::KIND_BYTE, pqbsf_pkg::ESC_MARK);
         push_beat(pqbsf_pkg::KIND_BYTE, value ^ pqbsf_pkg::ESC_FLIP);
      end else begin
         push_beat(pqbsf_pkg::KIND_BYTE, value);
      end
   endfunction

   function automatic void predict_line_beats(input logic [7:0] cmd, input logic [15:0] first,
                                              input logic [15:0] second,
                                              input logic [15:0] third);
      logic [15:0] positions[3];
      positions[0] = first;
      positions[1] = second;
      positions[2] = third;
      if (cmd == pqbsf_pkg::FRAME_START) begin
         push_beat(pqbsf_pkg::KIND_BYTE, pqbsf_pkg::FRAME_START);
         foreach (positions[i]) begin
            push_stuffed_byte(positions[i][15:8]);
            push_stuffed_byte(positions[i][7:0]);
         end
         push_beat(pqbsf_pkg::KIND_BYTE, pqbsf_pkg::FRAME_END);
      end else if (cmd == pqbsf_pkg::FRAME_END) begin
         push_beat(pqbsf_pkg::KIND_RESET, 8'h00);
      end else begin
         push_beat(pqbsf_pkg::KIND_HELP, 8'h00);
      end
      expected_beats[$].last = 1'b1;
   endfunction

   // ---------------- stimulus ----------------

   task automatic send_command(input logic [7:0] cmd, input logic [15:0] first,
                               input logic [15:0] second, input logic [15:0] third);
      @(negedge clock);
      while (stall_enable && $urandom_range(0, 99) < STALL_PERCENT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.command_byte = cmd;
      req_bus.position_first = first;
      req_bus.position_second = second;
      req_bus.position_third = third;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_line_beats(cmd, first, second, third);
   endtask

   // about three eighths of the position bytes hit the stuffed values
   function automatic logic [7:0] pick_position_byte();
      logic [7:0] value;
      case ($urandom_range(0, 7))
         0: value = pqbsf_pkg::FRAME_START;
         1: value = pqbsf_pkg::FRAME_END;
         2: value = pqbsf_pkg::ESC_MARK;
         default: value = 8'($urandom_range(0, 255));
      endcase
      return value;
   endfunction

   function automatic logic [15:0] pick_position();
      return {pick_position_byte(), pick_position_byte()};
   endfunction

   task automatic send_random_command();
      int unsigned roll;
      logic [7:0]  cmd;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         cmd = pqbsf_pkg::FRAME_START;
      else if (roll < 75)
         cmd = pqbsf_pkg::FRAME_END;
      else
         cmd = 8'($urandom_range(0, 255));
      send_command(cmd, pick_position(), pick_position(), pick_position());
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
   endtask

   // ---------------- tests ----------------

   task automatic test_command_corners();
      // help and reset beats carry a zero byte and close their run
      send_command(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_command(8'hFF, 16'h0000, 16'h0000, 16'h0000);
      send_command(pqbsf_pkg::ESC_MARK, 16'h1234, 16'h5678, 16'h9ABC);
      send_command(8'hAB, 16'hAAAA, 16'hBBBB, 16'h7D7D);
      send_command(8'hBA, 16'h0001, 16'h0002, 16'h0003);
      send_command(pqbsf_pkg::FRAME_END, 16'hFFFF, 16'h0000, 16'hAAAA);
      // plain frames, no stuffing
      send_command(pqbsf_pkg::FRAME_START, 16'h0000, 16'h0000, 16'h0000);
      send_command(pqbsf_pkg::FRAME_START, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // every position byte stuffed, longest frame
      send_command(pqbsf_pkg::FRAME_START, 16'hAAAA, 16'hBBBB, 16'h7D7D);
      send_command(pqbsf_pkg::FRAME_START, 16'h7DAA, 16'hBB7D, 16'hAABB);
      // stuffed byte in one half only
      send_command(pqbsf_pkg::FRAME_START, 16'hAA00, 16'h00BB, 16'h7D01);
      // near misses of the stuffed values
      send_command(pqbsf_pkg::FRAME_START, 16'hABBA, 16'h7C7E, 16'h8A9B);
      send_command(pqbsf_pkg::FRAME_START, 16'h5D5D, 16'h0A1B, 16'hEAFB);
      send_command(pqbsf_pkg::FRAME_START, 16'h8001, 16'h4002, 16'h2004);
      send_command(pqbsf_pkg::FRAME_END, 16'h5555, 16'hAAAA, 16'h5555);
      send_command(8'h01, 16'h8000, 16'h8000, 16'h8000);
   endtask

   task automatic test_back_to_back();
      stall_enable = 1'b0;
      repeat (40)
         send_random_command();
      stall_enable = 1'b1;
   endtask

   task automatic test_pause_until_drained();
      repeat (4)
         send_random_command();
      wait_until_drained();
      send_command(pqbsf_pkg::FRAME_START, 16'hAAAA, 16'hBBBB, 16'h7D7D);
      send_command(pqbsf_pkg::FRAME_END, 16'h0000, 16'h0000, 16'h0000);
      wait_until_drained();
      repeat (6)
         send_random_command();
   endtask

   task automatic test_random_mix();
      repeat (90)
         send_random_command();
   endtask

   // ---------------- result side ----------------

   always @(negedge clock) begin
      if (stall_enable)
         rsp_bus.ready = ($urandom_range(0, 99) >= STALL_PERCENT);
      else
         rsp_bus.ready = 1'b1;
   end

   always @(posedge clock) begin
      line_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing pending", 8'h00, rsp_bus.line_byte);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_bus.result_kind !== want.kind)
               report_mismatch("result_kind", 8'(want.kind), 8'(rsp_bus.result_kind));
            if (rsp_bus.line_byte !== want.data)
               report_mismatch("line_byte", want.data, rsp_bus.line_byte);
            if (rsp_bus.last_of_run !== want.last)
               report_mismatch("last_of_run", 8'(want.last), 8'(rsp_bus.last_of_run));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no beat for %0d cycles, %0d beats pending",
                  $realtime, WATCHDOG_LIMIT, expected_beats.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      repeat (2)
         @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_command_corners();
      test_back_to_back();
      test_pause_until_drained();
      test_random_mix();

      wait_until_drained();
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (expected_beats.size() != 0)
         report_mismatch("beats left pending", 8'h00, 8'(expected_beats.size()));

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
